### hw/rtl/lbp_pkg.sv
// Shared types and constants of the RGB 3x3 local binary pattern stream.
package lbp_pkg;

   // Fixed widths of the register fields and of the result fields.
   localparam int WIDTH_REG_BITS  = 11;
   localparam int HEIGHT_REG_BITS = 13;
   localparam int CSR_DATA_BITS   = 13;
   localparam int CSR_INDEX_BITS  = 1;
   localparam int IN_SAMPLE_BITS  = 8;
   localparam int CODE_BITS       = 8;
   localparam int OUT_X_BITS      = 10;
   localparam int OUT_Y_BITS      = 12;

   localparam logic [WIDTH_REG_BITS-1:0]  WIDTH_RESET  = 11'd640;
   localparam logic [HEIGHT_REG_BITS-1:0] HEIGHT_RESET = 13'd480;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_IMAGE_WIDTH  = 1'b0,
      CSR_IMAGE_HEIGHT = 1'b1
   } csr_index_type;

   // Which sides of the window lie inside the image.
   typedef struct packed {
      logic has_left;
      logic has_right;
      logic has_top;
      logic has_bottom;
   } border_type;

   // Weight of each window cell, indexed [column][row]; column 0 is left, row 0 is top.
   localparam logic [CODE_BITS-1:0] CELL_WEIGHT [3][3] = '{
      '{8'd1, 8'd128, 8'd64},
      '{8'd2, 8'd0,   8'd32},
      '{8'd4, 8'd8,   8'd16}
   };

endpackage

### hw/rtl/lbp_ram.sv
// Generic simple dual-port RAM with registered, read-first output.
module lbp_ram #(
   parameter int DATA_W = 24,
   parameter int DEPTH  = 1024,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/lbp_code.sv
// Pattern code of the three color channels from one 3x3 RGB window.
module lbp_code #(
   parameter int SAMPLE_BITS = 8,
   localparam int PIX_W = 3 * SAMPLE_BITS
) (
   input  logic [2:0][2:0][PIX_W-1:0]           window,
   input  lbp_pkg::border_type                  border,
   output logic [2:0][lbp_pkg::CODE_BITS-1:0]   codes
);

   always_comb begin
      logic [SAMPLE_BITS-1:0] centre;
      logic [SAMPLE_BITS-1:0] neighbor;
      logic                   use_cell;
      for (int ch = 0; ch < 3; ch++) begin
         codes[ch] = '0;
         centre = window[1][1][ch*SAMPLE_BITS +: SAMPLE_BITS];
         for (int c = 0; c < 3; c++) begin
            for (int r = 0; r < 3; r++) begin
               neighbor = window[c][r][ch*SAMPLE_BITS +: SAMPLE_BITS];
               use_cell = (c != 0 || border.has_left) && (c != 2 || border.has_right) &&
                          (r != 0 || border.has_top) && (r != 2 || border.has_bottom);
               // Nonzero weights are distinct single bits, so OR is the same as a sum.
               if (use_cell && neighbor >= centre) begin
                  codes[ch] = codes[ch] | lbp_pkg::CELL_WEIGHT[c][r];
               end
            end
         end
      end
   end

endmodule

### hw/rtl/lbp_3x3_rgb_stream.sv
// Top level of the streaming 3x3 local binary pattern on RGB pixels.
// A request completing its window is taken into stage 1 as the row stores are read; when stage 1
// advances, the window shifts and its code is loaded into the result register.
// Throughput: one request per cycle, except while a blocked result holds a code in stage 1.
// Reset clears counters, valid flags and the size registers (640 x 480); row stores are not
// cleared, since every entry that reaches a code is written first.
module lbp_3x3_rgb_stream #(
   parameter int MAX_WIDTH   = 1024,
   parameter int MAX_HEIGHT  = 4096,
   parameter int SAMPLE_BITS = 8
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [lbp_pkg::IN_SAMPLE_BITS-1:0]    req_red,
   input  logic [lbp_pkg::IN_SAMPLE_BITS-1:0]    req_green,
   input  logic [lbp_pkg::IN_SAMPLE_BITS-1:0]    req_blue,
   input  logic                                  req_pad,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [lbp_pkg::CODE_BITS-1:0]         rsp_lbp_red,
   output logic [lbp_pkg::CODE_BITS-1:0]         rsp_lbp_green,
   output logic [lbp_pkg::CODE_BITS-1:0]         rsp_lbp_blue,
   output logic [lbp_pkg::OUT_X_BITS-1:0]        rsp_out_x,
   output logic [lbp_pkg::OUT_Y_BITS-1:0]        rsp_out_y,
   output logic                                  rsp_last_pixel,
   input  logic                                  csr_write,
   input  logic [lbp_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [lbp_pkg::CSR_DATA_BITS-1:0]     csr_data
);

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int ROW_W = $clog2(MAX_HEIGHT);
   localparam int WSZ_W = COL_W + 1;
   localparam int HSZ_W = ROW_W + 1;
   localparam int PIX_W = 3 * SAMPLE_BITS;

   // Size registers.
   logic [lbp_pkg::WIDTH_REG_BITS-1:0]  width_ff, width_in;
   logic [lbp_pkg::HEIGHT_REG_BITS-1:0] height_ff, height_in;
   logic [WSZ_W-1:0] w;
   logic [HSZ_W-1:0] h;

   // Position counters.
   logic [COL_W-1:0] in_col_ff, in_col_in, emit_col_ff, emit_col_in;
   logic [ROW_W-1:0] in_row_ff, in_row_in, emit_row_ff, emit_row_in;
   logic             image_done_ff, image_done_in;

   logic             take, fire, last;
   logic             col_wrap, row_wrap, emit_col_wrap, emit_row_wrap;
   logic [PIX_W-1:0] sample;

   // Stage 1: request waiting for its row-store read data.
   logic                          s1_valid_ff, s1_valid_in;
   logic                          s1_fire_ff, s1_fire_in;
   logic                          s1_last_ff, s1_last_in;
   logic                          s1_byp_ff, s1_byp_in;
   logic [COL_W-1:0]              s1_col_ff, s1_col_in;
   logic [PIX_W-1:0]              s1_pix_ff, s1_pix_in;
   logic [PIX_W-1:0]              s1_fwd_ff, s1_fwd_in;
   lbp_pkg::border_type           s1_border_ff, s1_border_in;
   logic [lbp_pkg::OUT_X_BITS-1:0] s1_x_ff, s1_x_in;
   logic [lbp_pkg::OUT_Y_BITS-1:0] s1_y_ff, s1_y_in;
   logic                          s1_adv;

   logic [PIX_W-1:0] older_rd, newer_rd, older_eff;

   logic [2:0][2:0][PIX_W-1:0]            window_ff, window_in;
   logic [2:0][lbp_pkg::CODE_BITS-1:0]    codes;

   // Result register.
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [lbp_pkg::CODE_BITS-1:0]  rsp_red_ff, rsp_red_in;
   logic [lbp_pkg::CODE_BITS-1:0]  rsp_green_ff, rsp_green_in;
   logic [lbp_pkg::CODE_BITS-1:0]  rsp_blue_ff, rsp_blue_in;
   logic [lbp_pkg::OUT_X_BITS-1:0] rsp_x_ff, rsp_x_in;
   logic [lbp_pkg::OUT_Y_BITS-1:0] rsp_y_ff, rsp_y_in;
   logic                           rsp_last_ff, rsp_last_in;

   // ---------------------------------------------------------------------------------------
   // Configuration.
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_write) begin
         case (lbp_pkg::csr_index_type'(csr_index))
            lbp_pkg::CSR_IMAGE_WIDTH: begin
               width_in = csr_data[lbp_pkg::WIDTH_REG_BITS-1:0];
            end
            lbp_pkg::CSR_IMAGE_HEIGHT: begin
               height_in = csr_data[lbp_pkg::HEIGHT_REG_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Sizes in use are clamped to 1..MAX.
   always_comb begin
      logic [31:0] w_wide;
      logic [31:0] h_wide;
      w_wide = 32'(width_ff);
      h_wide = 32'(height_ff);
      if (w_wide == 32'd0) begin
         w_wide = 32'd1;
      end else if (w_wide > 32'(MAX_WIDTH)) begin
         w_wide = 32'(MAX_WIDTH);
      end
      if (h_wide == 32'd0) begin
         h_wide = 32'd1;
      end else if (h_wide > 32'(MAX_HEIGHT)) begin
         h_wide = 32'(MAX_HEIGHT);
      end
      w = w_wide[WSZ_W-1:0];
      h = h_wide[HSZ_W-1:0];
   end

   // ---------------------------------------------------------------------------------------
   // Request side: all position bookkeeping is settled when the request is taken.
   assign s1_adv    = s1_valid_ff && (!s1_fire_ff || !rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_adv;

   // A pad while pixels are expected, or a pixel during the flush, is dropped.
   assign take = req_valid && req_ready && (req_pad == image_done_ff);

   assign sample = req_pad ? '0 :
                   {SAMPLE_BITS'(req_blue), SAMPLE_BITS'(req_green), SAMPLE_BITS'(req_red)};

   assign col_wrap      = (WSZ_W'(in_col_ff) + WSZ_W'(1)) >= w;
   assign row_wrap      = (HSZ_W'(in_row_ff) + HSZ_W'(1)) >= h;
   assign emit_col_wrap = (WSZ_W'(emit_col_ff) + WSZ_W'(1)) >= w;
   assign emit_row_wrap = (HSZ_W'(emit_row_ff) + HSZ_W'(1)) >= h;
   assign last          = emit_col_wrap && emit_row_wrap;

   always_comb begin
      in_col_in     = in_col_ff;
      in_row_in     = in_row_ff;
      emit_col_in   = emit_col_ff;
      emit_row_in   = emit_row_ff;
      image_done_in = image_done_ff;
      fire          = 1'b0;
      if (take) begin
         if (!image_done_ff) begin
            fire = (in_row_ff >= ROW_W'(2)) || (in_row_ff == ROW_W'(1) && in_col_ff != '0);
            if (col_wrap) begin
               in_col_in = '0;
               if (row_wrap) begin
                  image_done_in = 1'b1;
                  in_row_in     = '0;
               end else begin
                  in_row_in = in_row_ff + ROW_W'(1);
               end
            end else begin
               in_col_in = in_col_ff + COL_W'(1);
            end
         end else begin
            // A one-row image has nothing to flush out on its first pad.
            fire = !(h == HSZ_W'(1) && in_row_ff == '0 && in_col_ff == '0);
            if (col_wrap) begin
               in_col_in = '0;
               in_row_in = ROW_W'(1);
            end else begin
               in_col_in = in_col_ff + COL_W'(1);
            end
         end
         if (fire) begin
            if (emit_col_wrap) begin
               emit_col_in = '0;
               emit_row_in = emit_row_wrap ? '0 : emit_row_ff + ROW_W'(1);
            end else begin
               emit_col_in = emit_col_ff + COL_W'(1);
            end
            // The final code of the flush returns the block to the start of an image.
            if (image_done_ff && last) begin
               image_done_in = 1'b0;
               in_col_in     = '0;
               in_row_in     = '0;
               emit_col_in   = '0;
               emit_row_in   = '0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // Stage 1 capture.
   always_comb begin
      s1_valid_in  = take ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);
      s1_fire_in   = s1_fire_ff;
      s1_last_in   = s1_last_ff;
      s1_byp_in    = s1_byp_ff;
      s1_col_in    = s1_col_ff;
      s1_pix_in    = s1_pix_ff;
      s1_fwd_in    = s1_fwd_ff;
      s1_border_in = s1_border_ff;
      s1_x_in      = s1_x_ff;
      s1_y_in      = s1_y_ff;
      if (take) begin
         s1_fire_in            = fire;
         s1_last_in            = last;
         s1_col_in             = in_col_ff;
         s1_pix_in             = sample;
         s1_border_in.has_left   = emit_col_ff != '0;
         s1_border_in.has_right  = !emit_col_wrap;
         s1_border_in.has_top    = emit_row_ff != '0;
         s1_border_in.has_bottom = !emit_row_wrap;
         s1_x_in               = lbp_pkg::OUT_X_BITS'(emit_col_ff);
         s1_y_in               = lbp_pkg::OUT_Y_BITS'(emit_row_ff);
         // The older row is written as stage 1 advances, not at acceptance; a request on the same column as the
         // one ahead of it takes that write data instead of the stale RAM word.
         s1_byp_in             = s1_valid_ff && (s1_col_ff == in_col_ff);
         s1_fwd_in             = newer_rd;
      end
   end

   lbp_ram #(
      .DATA_W (PIX_W),
      .DEPTH  (MAX_WIDTH)
   ) u_older_row (
      .clock   (clock),
      .wr_en   (s1_adv),
      .wr_addr (s1_col_ff),
      .wr_data (newer_rd),
      .rd_en   (take),
      .rd_addr (in_col_ff),
      .rd_data (older_rd)
   );

   lbp_ram #(
      .DATA_W (PIX_W),
      .DEPTH  (MAX_WIDTH)
   ) u_newer_row (
      .clock   (clock),
      .wr_en   (take),
      .wr_addr (in_col_ff),
      .wr_data (sample),
      .rd_en   (take),
      .rd_addr (in_col_ff),
      .rd_data (newer_rd)
   );

   assign older_eff = s1_byp_ff ? s1_fwd_ff : older_rd;

   // ---------------------------------------------------------------------------------------
   // Window shift and code.
   always_comb begin
      window_in = window_ff;
      if (s1_adv) begin
         window_in[0]    = window_ff[1];
         window_in[1]    = window_ff[2];
         window_in[2][0] = older_eff;
         window_in[2][1] = newer_rd;
         window_in[2][2] = s1_pix_ff;
      end
   end

   lbp_code #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_code (
      .window (window_in),
      .border (s1_border_ff),
      .codes  (codes)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_red_in   = rsp_red_ff;
      rsp_green_in = rsp_green_ff;
      rsp_blue_in  = rsp_blue_ff;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_last_in  = rsp_last_ff;
      if (s1_adv && s1_fire_ff) begin
         rsp_valid_in = 1'b1;
         rsp_red_in   = codes[0];
         rsp_green_in = codes[1];
         rsp_blue_in  = codes[2];
         rsp_x_in     = s1_x_ff;
         rsp_y_in     = s1_y_ff;
         rsp_last_in  = s1_last_ff;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff      <= lbp_pkg::WIDTH_RESET;
         height_ff     <= lbp_pkg::HEIGHT_RESET;
         in_col_ff     <= '0;
         in_row_ff     <= '0;
         emit_col_ff   <= '0;
         emit_row_ff   <= '0;
         image_done_ff <= 1'b0;
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         width_ff      <= width_in;
         height_ff     <= height_in;
         in_col_ff     <= in_col_in;
         in_row_ff     <= in_row_in;
         emit_col_ff   <= emit_col_in;
         emit_row_ff   <= emit_row_in;
         image_done_ff <= image_done_in;
         s1_valid_ff   <= s1_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_fire_ff   <= s1_fire_in;
      s1_last_ff   <= s1_last_in;
      s1_byp_ff    <= s1_byp_in;
      s1_col_ff    <= s1_col_in;
      s1_pix_ff    <= s1_pix_in;
      s1_fwd_ff    <= s1_fwd_in;
      s1_border_ff <= s1_border_in;
      s1_x_ff      <= s1_x_in;
      s1_y_ff      <= s1_y_in;
      window_ff    <= window_in;
      rsp_red_ff   <= rsp_red_in;
      rsp_green_ff <= rsp_green_in;
      rsp_blue_ff  <= rsp_blue_in;
      rsp_x_ff     <= rsp_x_in;
      rsp_y_ff     <= rsp_y_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_lbp_red    = rsp_red_ff;
   assign rsp_lbp_green  = rsp_green_ff;
   assign rsp_lbp_blue   = rsp_blue_ff;
   assign rsp_out_x      = rsp_x_ff;
   assign rsp_out_y      = rsp_y_ff;
   assign rsp_last_pixel = rsp_last_ff;

   // ---------------------------------------------------------------------------------------
   // Assertions.

   // The request side only stalls behind a code that cannot leave the result register.
   a_ready_stall: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (s1_valid_ff && s1_fire_ff && rsp_valid_ff && !rsp_ready))
      else $error("request side stalled without a blocked result");

   // A stalled stage 1 request keeps its place and its column.
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_adv) |=> (s1_valid_ff && $stable(s1_col_ff)))
      else $error("stage 1 request lost while stalled");

   // The final code of the flush leaves all counters at the start of a new image.
   a_flush_end: assert property (@(posedge clock) disable iff (reset)
      (take && image_done_ff && fire && last) |=>
         (in_col_ff == '0 && in_row_ff == '0 && emit_col_ff == '0 &&
          emit_row_ff == '0 && !image_done_ff))
      else $error("counters not cleared after the final flush code");

endmodule
